@@ hdl/esr_pkg.sv @@
// shared types and codes of the event subscription router
`default_nettype none
package esr_pkg;

    localparam int CFG_W        = 5;
    localparam int CMD_W        = 3;
    localparam int KIND_W       = 2;
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(RESULT_LIMIT);

    localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNSUB     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNSUB_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PUBLISH   = 3'd4;

    localparam logic [KIND_W-1:0] KIND_DONE           = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELIVERY       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NO_SUBSCRIBERS = 2'd3;

    typedef struct packed {
        logic [7:0]  evt;
        logic [7:0]  grp;
        logic [31:0] mask;
    } rec_t;

endpackage
`default_nettype wire

@@ hdl/event_subscription_router.sv @@
// event subscription router: record table, subscription bits and command sequencer
//
// Records (event, group, mask) live in a single-port synchronous memory with a registered
// read; subscription bits are flip-flops cleared by reset, so no clearing pass is needed.
// A load or unknown command, or a scan with no records in use, goes straight to the done
// state. Subscribe, unsubscribe, unsubscribe-all and publish scan the records in use
// (cfg_count_reg, saturated to MAX_RECORDS) at one record per cycle through the memory
// read port, except while a publish delivery is stalled by the output side; subscribe and
// unsubscribe stop at their first full match. One command is in flight at a time; a new
// word is accepted once its final result has moved into the output register.
`default_nettype none
module event_subscription_router #(
    parameter int MAX_RECORDS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [esr_pkg::CFG_W-1:0]  cfg_write_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [esr_pkg::CMD_W-1:0]  cmd,
    input  wire logic [3:0]                 entry_index,
    input  wire logic [7:0]                 event_code,
    input  wire logic [7:0]                 group_id,
    input  wire logic [31:0]                flag_mask,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [esr_pkg::KIND_W-1:0]      result_kind,
    output logic [7:0]                      target_group,
    output logic [31:0]                     set_mask,
    output logic                            last
);
    import esr_pkg::*;

    localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;
    localparam int SW = (CW > 4) ? CW : 4;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    rec_t rec_mem [MAX_RECORDS];
    rec_t rd_data_reg;
    logic mem_we;
    logic mem_re;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;
    rec_t wr_data;

    logic [1:0]             state_reg, state_next;
    logic [CFG_W-1:0]       cfg_count_reg, cfg_count_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [7:0]             ev_reg, ev_next;
    logic [7:0]             grp_reg, grp_next;
    logic [31:0]            mask_reg, mask_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [KIND_W-1:0]      pend_kind_reg, pend_kind_next;
    logic [7:0]             pend_grp_reg, pend_grp_next;
    logic [31:0]            pend_mask_reg, pend_mask_next;
    logic [MAX_RECORDS-1:0] sub_reg, sub_next;
    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic [7:0]             out_grp_reg, out_grp_next;
    logic [31:0]            out_mask_reg, out_mask_next;
    logic                   out_last_reg, out_last_next;

    logic [NW-1:0] cfg_ext;
    logic [NW-1:0] n_active;
    logic [NW-1:0] n_m1;
    logic [IW-1:0] last_idx;
    logic          n_zero;
    logic [SW-1:0] slot_ext;
    logic          slot_ok;
    logic          out_free;
    logic          at_end;
    logic          full_match;
    logic          hit;
    logic          advance;

    assign cfg_ext  = NW'(cfg_count_reg);
    assign n_active = (cfg_ext > NW'(MAX_RECORDS)) ? NW'(MAX_RECORDS) : cfg_ext;
    assign n_m1     = n_active - NW'(1);
    assign last_idx = n_m1[IW-1:0];
    assign n_zero   = (n_active == '0);
    assign slot_ext = SW'(entry_index);
    assign slot_ok  = (slot_ext < SW'(MAX_RECORDS));
    assign out_free = !out_valid_reg || out_ready;
    assign at_end   = (idx_reg == last_idx);
    assign full_match = (rd_data_reg.evt == ev_reg) && (rd_data_reg.grp == grp_reg)
                        && (rd_data_reg.mask == mask_reg);
    assign hit      = (rd_data_reg.evt == ev_reg) && sub_reg[idx_reg];
    assign wr_addr  = slot_ext[IW-1:0];
    assign wr_data  = '{evt: event_code, grp: group_id, mask: flag_mask};

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign target_group = out_grp_reg;
    assign set_mask     = out_mask_reg;
    assign last         = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cfg_count_next  = cfg_write_en ? cfg_write_data : cfg_count_reg;
        cmd_next        = cmd_reg;
        ev_next         = ev_reg;
        grp_next        = grp_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_grp_next   = pend_grp_reg;
        pend_mask_next  = pend_mask_reg;
        sub_next        = sub_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_grp_next    = out_grp_reg;
        out_mask_next   = out_mask_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        rd_addr         = idx_reg + IW'(1);
        advance         = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd;
                    ev_next         = event_code;
                    grp_next        = group_id;
                    mask_next       = flag_mask;
                    idx_next        = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    pend_kind_next  = KIND_DONE;
                    pend_grp_next   = '0;
                    pend_mask_next  = '0;
                    state_next      = ST_DONE;
                    case (cmd)
                        CMD_LOAD:
                        begin
                            if (slot_ok)
                            begin
                                mem_we = 1'b1;
                                sub_next[slot_ext[IW-1:0]] = 1'b0;
                            end
                        end
                        CMD_SUB, CMD_UNSUB, CMD_UNSUB_ALL, CMD_PUBLISH:
                        begin
                            if (n_zero)
                            begin
                                if (cmd == CMD_PUBLISH)
                                    pend_kind_next = KIND_NO_SUBSCRIBERS;
                                else if (cmd != CMD_UNSUB_ALL)
                                    pend_kind_next = KIND_NOT_FOUND;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            pend_kind_next = KIND_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                case (cmd_reg)
                    CMD_SUB, CMD_UNSUB:
                    begin
                        if (full_match)
                        begin
                            sub_next[idx_reg] = (cmd_reg == CMD_SUB);
                            pend_kind_next    = KIND_DONE;
                            state_next        = ST_DONE;
                        end
                        else if (at_end)
                        begin
                            pend_kind_next = KIND_NOT_FOUND;
                            state_next     = ST_DONE;
                        end
                    end
                    CMD_UNSUB_ALL:
                    begin
                        if (rd_data_reg.grp == grp_reg)
                            sub_next[idx_reg] = 1'b0;
                        if (at_end)
                            state_next = ST_DONE;
                    end
                    CMD_PUBLISH:
                    begin
                        if (hit && pend_valid_reg && !out_free)
                        begin
                            advance = 1'b0;
                        end
                        else if (hit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = pend_kind_reg;
                                out_grp_next   = pend_grp_reg;
                                out_mask_next  = pend_mask_reg;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_DELIVERY;
                            pend_grp_next   = rd_data_reg.grp;
                            pend_mask_next  = rd_data_reg.mask;
                            cnt_next        = cnt_reg + CNT_W'(1);
                            if (at_end || (cnt_reg == CNT_W'(RESULT_LIMIT - 1)))
                                state_next = ST_DONE;
                        end
                        else if (at_end)
                        begin
                            if (!pend_valid_reg)
                                pend_kind_next = KIND_NO_SUBSCRIBERS;
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
                if (advance && (state_next == ST_SCAN))
                begin
                    mem_re   = 1'b1;
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_grp_next   = pend_grp_reg;
                    out_mask_next  = pend_mask_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            rec_mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= rec_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cfg_count_reg  <= '0;
            sub_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_count_reg  <= cfg_count_next;
            sub_reg        <= sub_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ev_reg        <= ev_next;
        grp_reg       <= grp_next;
        mask_reg      <= mask_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        pend_kind_reg <= pend_kind_next;
        pend_grp_reg  <= pend_grp_next;
        pend_mask_reg <= pend_mask_next;
        out_kind_reg  <= out_kind_next;
        out_grp_reg   <= out_grp_next;
        out_mask_reg  <= out_mask_next;
        out_last_reg  <= out_last_next;
    end

endmodule
`default_nettype wire

@@ hdl/esr_checker.sv @@
// port-level checks of the event subscription router and their binding
`default_nettype none
module esr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [esr_pkg::KIND_W-1:0] result_kind,
    input wire logic [7:0]                 target_group,
    input wire logic [31:0]                set_mask,
    input wire logic                       last
);
    import esr_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(target_group) && $stable(set_mask) && $stable(last))
    else $error("stalled result word changed");

    // only deliveries carry group and mask, and anything else ends its command
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind != KIND_DELIVERY) |->
            last && (target_group == 8'd0) && (set_mask == 32'd0))
    else $error("non-delivery word malformed");

    // one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

    // a command whose final word is still pending blocks new input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
    else $error("input ready before final word of command");

endmodule

bind event_subscription_router esr_checker u_esr_checker (.*);
`default_nettype wire
